>>> sv/ssm_pkg.sv
package ssm_pkg;

  // Field widths
  localparam int AddrW    = 40;
  localparam int LenW     = 24;
  localparam int BlkW     = 21;
  localparam int VolW     = 4;
  localparam int NumVolW  = 5;
  localparam int ReqW     = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 21;

  // Limits
  localparam int MaxVolumes  = 16;
  localparam int MaxSegments = 64;
  localparam logic [BlkW-1:0] DefaultBlock = 21'd8192;
  localparam logic [BlkW-1:0] LargestBlock = 21'd1048576;

  // Stripe width n * bs, at most MaxVolumes * LargestBlock
  localparam int WidthW = $clog2(MaxVolumes * 1048576 + 1);
  localparam int DivCntW = $clog2(AddrW);
  localparam int VolStepW = $clog2(VolW);
  // Width of the segment-limit compare: seglen + (MaxSegments - 1) * bs
  localparam int LimW = BlkW + $clog2(MaxSegments) + 1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegNumVolumes = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBlockSize  = 2'd1;

  // Request codes
  localparam logic [ReqW-1:0] OpRead  = 2'd0;
  localparam logic [ReqW-1:0] OpWrite = 2'd1;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ILLEGAL  = 2'd1,
    ERR_TOO_MANY = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_VOL,
    ST_CHECK,
    ST_EMIT,
    ST_SINGLE
  } state_t;

endpackage

>>> sv/stripe_segment_mapper_unit.sv
// Channel  | direction | handshake             | word
// ---------+-----------+-----------------------+---------------------------------------
// in       | input     | in_valid / in_ready   | req_type, first_byte, length
// out      | output    | out_valid / out_ready | volume, vol_offset, seg_len, buf_offset,
//          |           |                       | seek_all, error, last
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request first runs a bit-serial divide of first_byte by the stripe
// width, then splits the remainder into volume and in-block offset, then
// checks the segment limit; after that it gives one segment per cycle while
// out_ready stays high.
// Illegal requests skip the divide and give their single word directly.
// Reset (rst, synchronous) restores num_volumes 1, block_size 8192 and forgets
// the stream position. A stalled out_ready holds the segment sequencer.
module stripe_segment_mapper_unit import ssm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ReqW-1:0]     req_type,
  input  logic [AddrW-1:0]    first_byte,
  input  logic [LenW-1:0]     length,
  // segment channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VolW-1:0]     volume,
  output logic [AddrW-1:0]    vol_offset,
  output logic [BlkW-1:0]     seg_len,
  output logic [LenW-1:0]     buf_offset,
  output logic                seek_all,
  output logic [1:0]          error,
  output logic                last,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  state_t state, state_next;

  // configuration
  logic [NumVolW-1:0] num_volumes;
  logic [BlkW-1:0]    block_size;
  logic [NumVolW-1:0] n_eff;
  logic [BlkW-1:0]    bs_eff;

  // stream position
  logic [AddrW:0]     next_byte;
  logic               next_valid;
  logic               last_op;

  // per-request working registers
  logic               op_r;
  logic [AddrW-1:0]   first_r;
  logic [LenW-1:0]    len_r;
  logic [NumVolW-1:0] n_r;
  logic [BlkW-1:0]    bs_r;
  logic [WidthW-1:0]  width;
  logic [AddrW-1:0]   dvd;
  logic [WidthW-1:0]  rem;
  logic [AddrW-1:0]   base;
  logic [DivCntW-1:0] div_cnt;
  logic [VolStepW-1:0] vstep;
  logic [VolW-1:0]    vol;
  logic [BlkW-1:0]    segl;
  logic [LenW-1:0]    left;
  logic [LenW-1:0]    buf_pos;
  logic               first_seg;
  logic               seek_r;
  err_t               single_err;

  // control
  logic               in_acc;
  logic               out_load;

  // effective configuration
  always_comb begin
    if (num_volumes == '0) n_eff = NumVolW'(1);
    else if (num_volumes > NumVolW'(MaxVolumes)) n_eff = NumVolW'(MaxVolumes);
    else n_eff = num_volumes;
    if (block_size == '0) bs_eff = DefaultBlock;
    else if (block_size > LargestBlock) bs_eff = LargestBlock;
    else bs_eff = block_size;
  end

  // stripe width, n * bs
  logic [NumVolW+BlkW-1:0] prod;
  assign prod = {{BlkW{1'b0}}, n_eff} * {{NumVolW{1'b0}}, bs_eff};

  // one restoring divide step
  logic [WidthW:0]   trial;
  logic              qbit;
  assign trial = {rem, dvd[AddrW-1]};
  assign qbit  = (trial >= {1'b0, width});

  // volume split step: compare against bs << vstep
  logic [WidthW-1:0] vsub;
  logic              vbit;
  assign vsub = {{(WidthW-BlkW){1'b0}}, bs_r} << vstep;
  assign vbit = (rem >= vsub);

  // segment limit: first segment plus (MaxSegments - 1) whole blocks
  logic [BlkW-1:0] seg_first;
  logic [LimW-1:0] bs_many;
  logic [LimW-1:0] seg_limit;
  logic            too_many;
  logic            seek_calc;
  assign seg_first = bs_r - rem[BlkW-1:0];
  assign bs_many   = LimW'({{(LimW-BlkW){1'b0}}, bs_r} * LimW'(MaxSegments - 1));
  assign seg_limit = {{(LimW-BlkW){1'b0}}, seg_first} + bs_many;
  assign too_many  = ({{(LimW-LenW){1'b0}}, len_r} > seg_limit);
  assign seek_calc = !next_valid || (next_byte != {1'b0, first_r}) || (last_op != op_r);

  // segment step
  logic [BlkW-1:0] seg_now;
  logic [LenW-1:0] left_next;
  logic [AddrW-1:0] off_now;
  logic            vol_wrap;
  assign seg_now   = ({{(LenW-BlkW){1'b0}}, segl} > left) ? left[BlkW-1:0] : segl;
  assign left_next = left - {{(LenW-BlkW){1'b0}}, seg_now};
  assign off_now   = base + (first_seg ? {{(AddrW-BlkW){1'b0}}, rem[BlkW-1:0]} : '0);
  assign vol_wrap  = ({1'b0, vol} + NumVolW'(1)) == n_r;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == OpRead || req_type == OpWrite) state_next = ST_DIV;
          else state_next = ST_SINGLE;
        end
      end
      ST_DIV: begin
        if (div_cnt == DivCntW'(AddrW - 1)) state_next = ST_VOL;
      end
      ST_VOL: begin
        if (vstep == '0) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (too_many || len_r == '0) state_next = ST_SINGLE;
        else state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load && left_next == '0) state_next = ST_IDLE;
      end
      ST_SINGLE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    out_load  = (state == ST_EMIT || state == ST_SINGLE) && (!out_valid || out_ready);
  end
  assign in_acc = in_valid && in_ready;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      num_volumes <= NumVolW'(1);
      block_size  <= DefaultBlock;
      next_byte   <= '0;
      next_valid  <= 1'b0;
      last_op     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegNumVolumes) num_volumes <= cfg_data[NumVolW-1:0];
        else if (cfg_index == RegBlockSize) block_size <= cfg_data[BlkW-1:0];
      end
      // position update once the request is known to be legal
      if (state == ST_CHECK && !too_many) begin
        next_byte  <= {1'b0, first_r} + {{(AddrW+1-LenW){1'b0}}, len_r};
        next_valid <= 1'b1;
        if (len_r != '0) last_op <= op_r;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          op_r       <= req_type[0];
          first_r    <= first_byte;
          len_r      <= length;
          dvd        <= first_byte;
          n_r        <= n_eff;
          bs_r       <= bs_eff;
          width      <= prod[WidthW-1:0];
          rem        <= '0;
          base       <= '0;
          vol        <= '0;
          div_cnt    <= '0;
          vstep      <= VolStepW'(VolW - 1);
          single_err <= ERR_ILLEGAL;
        end
      end
      // quotient bits come out MSB first; base accumulates quotient * bs
      ST_DIV: begin
        rem     <= qbit ? WidthW'(trial - {1'b0, width}) : trial[WidthW-1:0];
        base    <= {base[AddrW-2:0], 1'b0} + (qbit ? {{(AddrW-BlkW){1'b0}}, bs_r} : '0);
        dvd     <= {dvd[AddrW-2:0], 1'b0};
        div_cnt <= div_cnt + DivCntW'(1);
      end
      ST_VOL: begin
        if (vbit) begin
          rem <= rem - vsub;
          vol[vstep] <= 1'b1;
        end
        vstep <= vstep - VolStepW'(1);
      end
      ST_CHECK: begin
        seek_r     <= seek_calc;
        segl       <= seg_first;
        left       <= len_r;
        buf_pos    <= '0;
        first_seg  <= 1'b1;
        single_err <= too_many ? ERR_TOO_MANY : ERR_NONE;
      end
      ST_EMIT: begin
        if (out_load) begin
          left      <= left_next;
          buf_pos   <= buf_pos + {{(LenW-BlkW){1'b0}}, seg_now};
          first_seg <= 1'b0;
          segl      <= bs_r;
          if (vol_wrap) begin
            vol  <= '0;
            base <= base + {{(AddrW-BlkW){1'b0}}, bs_r};
          end else begin
            vol <= vol + VolW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_EMIT) begin
        volume     <= vol;
        vol_offset <= off_now;
        seg_len    <= seg_now;
        buf_offset <= buf_pos;
        seek_all   <= seek_r;
        error      <= ERR_NONE;
        last       <= (left_next == '0);
      end else begin
        volume     <= '0;
        vol_offset <= '0;
        seg_len    <= '0;
        buf_offset <= '0;
        seek_all   <= (single_err == ERR_NONE) ? seek_r : 1'b0;
        error      <= single_err;
        last       <= 1'b1;
      end
    end
  end

  // error words are single and empty
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && error != ERR_NONE |-> last && seg_len == '0 && !seek_all)
    else $error("error word not single or not empty");

  // a request blocks the input until its words are produced
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // non-final data words carry bytes
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && error == ERR_NONE && !last |-> seg_len != '0)
    else $error("empty middle segment");

  // volume counter stays inside the stripe
  a_vol_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> {1'b0, vol} < n_r)
    else $error("volume index out of range");

endmodule
